FILE: design/mfm_pkg.sv
`timescale 1ns / 1ps
// Package for the clause 22 MDIO management frame master.
// Holds the word layouts, configuration types, register indexes and frame constants.
package mfm_pkg;

    // Input word, last field in the lowest bits.
    typedef struct packed {
        logic [1:0]  pad;
        logic        mdio_in;
        logic [15:0] write_data;
        logic [4:0]  register_address;
        logic [4:0]  phy_address;
        logic [1:0]  opcode;
        logic        request;
    } in_word_t;

    // Result word, last field in the lowest bits.
    typedef struct packed {
        logic [2:0]  pad;
        logic [15:0] read_data;
        logic        done_res;
        logic        busy_res;
        logic        mdio_drive;
        logic        mdio_out;
        logic        mdc;
    } res_word_t;

    typedef struct packed {
        logic [7:0] half_period_cycles;
        logic [5:0] preamble_bits;
        logic [1:0] start_bits;
    } cfg_t;

    typedef enum logic [1:0] {
        CFG_HALF_PERIOD = 2'd0,
        CFG_PREAMBLE    = 2'd1,
        CFG_START       = 2'd2
    } cfg_index_t;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd50;
    localparam logic [5:0] PREAMBLE_RESET    = 6'd32;
    localparam logic [1:0] START_RESET       = 2'b01;

    localparam logic [5:0] MAX_PREAMBLE    = 6'd32;
    localparam logic [6:0] HEADER_CELLS    = 7'd14;
    localparam logic [6:0] WRITE_LAST_CELL = 7'd32;
    localparam logic [6:0] READ_TA_CELL    = 7'd14;
    localparam logic [6:0] READ_LAST_CELL  = 7'd31;
    localparam logic [1:0] TA_PATTERN      = 2'b10;

endpackage

FILE: design/mdio_management_frame_master.sv
`timescale 1ns / 1ps
// Top level of the clause 22 MDIO management frame master.
// Holds the configuration registers and the result register; uses mfm_pkg and mfm_frame_engine.
//
//  Channel  Direction  Handshake           Payload
//  s_*      in         s_tvalid/s_tready   s_tdata: one clock tick of request and pin sample
//  m_*      out        m_tvalid/m_tready   m_tdata: pin levels, status and read data
//  cfg_*    in         cfg_valid/cfg_ready cfg_index, cfg_data: register write
//
// Each input word yields one result word, registered, in the cycle after it is accepted.
// One word per cycle is sustained while m_tready is high. The result register is refilled in
// the cycle it is taken, so s_tready follows m_tready whenever a result is waiting.
// Reset clears the frame state and loads the register defaults (50, 32, 01).
// Configuration writes are always taken and act from the next cycle.
module mdio_management_frame_master (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // request, opcode[1:0], phy_address[4:0], register_address[4:0],
    // write_data[15:0], mdio_in, zero fill
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // mdc, mdio_out, mdio_drive, busy_res, done_res, read_data[15:0], zero fill
    output logic [23:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import mfm_pkg::*;

    cfg_t      cfg_reg;
    in_word_t  in_word;
    res_word_t res_word;
    res_word_t out_reg;
    logic      out_valid_reg;
    logic      step;

    assign in_word   = in_word_t'(s_tdata);
    assign s_tready  = !out_valid_reg || m_tready;
    assign step      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_cycles <= HALF_PERIOD_RESET;
            cfg_reg.preamble_bits      <= PREAMBLE_RESET;
            cfg_reg.start_bits         <= START_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HALF_PERIOD: cfg_reg.half_period_cycles <= cfg_data;
                CFG_PREAMBLE:    cfg_reg.preamble_bits      <= cfg_data[5:0];
                CFG_START:       cfg_reg.start_bits         <= cfg_data[1:0];
                default:         ;
            endcase
        end
    end

    mfm_frame_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .in_word  (in_word),
        .cfg      (cfg_reg),
        .res_word (res_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= res_word;
        end
    end

    a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> m_tvalid)
        else $error("accepted word produced no result");

    a_out_drive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.mdio_out |-> out_reg.mdio_drive)
        else $error("mdio_out high while MDIO is released");

    a_out_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.done_res |-> out_reg.busy_res)
        else $error("done without busy");

endmodule

FILE: design/mfm_frame_engine.sv
`timescale 1ns / 1ps
// Frame sequencer: cell counter, MDC half-period divider and shift registers.
// Uses mfm_pkg for word layouts and frame constants.
module mfm_frame_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  mfm_pkg::in_word_t in_word,
    input  mfm_pkg::cfg_t     cfg,
    output mfm_pkg::res_word_t res_word
);
    import mfm_pkg::*;

    logic        active_reg, active_next;
    logic [6:0]  cell_reg, cell_next;
    logic        second_half_reg, second_half_next;
    logic [7:0]  div_reg, div_next;
    logic [31:0] shift_reg, shift_next;
    logic        read_frame_reg, read_frame_next;
    logic [15:0] sampled_reg, sampled_next;

    logic [5:0] pre;
    logic [7:0] half;
    logic [6:0] k;
    logic       driven;
    logic       sample;
    logic       last;
    logic       bit_value;
    logic       half_end;

    always_comb
    begin
        active_next      = active_reg;
        cell_next        = cell_reg;
        second_half_next = second_half_reg;
        div_next         = div_reg;
        shift_next       = shift_reg;
        read_frame_next  = read_frame_reg;
        sampled_next     = sampled_reg;

        pre       = (cfg.preamble_bits > MAX_PREAMBLE) ? MAX_PREAMBLE : cfg.preamble_bits;
        half      = (cfg.half_period_cycles == 8'd0) ? 8'd1 : cfg.half_period_cycles;
        k         = cell_reg - {1'b0, pre};
        driven    = 1'b0;
        sample    = 1'b0;
        last      = 1'b0;
        bit_value = 1'b0;
        half_end  = ({1'b0, div_reg} + 9'd1) >= {1'b0, half};

        res_word = '0;

        if (!active_reg)
        begin
            if (in_word.request)
            begin
                shift_next = {cfg.start_bits, in_word.opcode, in_word.phy_address,
                              in_word.register_address, TA_PATTERN, in_word.write_data};
                read_frame_next  = in_word.opcode[1];
                active_next      = 1'b1;
                cell_next        = '0;
                second_half_next = 1'b0;
                div_next         = '0;
            end
        end
        else
        begin
            res_word.busy_res = 1'b1;
            if (cell_reg < {1'b0, pre})
            begin
                driven    = 1'b1;
                bit_value = 1'b1;
            end
            else if ((k < HEADER_CELLS) || (!read_frame_reg && (k < WRITE_LAST_CELL)))
            begin
                driven    = 1'b1;
                bit_value = shift_reg[5'd31 - k[4:0]];
            end
            else if (read_frame_reg)
            begin
                sample = (k > READ_TA_CELL) && (k < READ_LAST_CELL);
                last   = (k >= READ_LAST_CELL);
            end
            else
            begin
                last = 1'b1;
            end

            res_word.mdio_drive = driven;
            res_word.mdio_out   = driven & bit_value;
            res_word.mdc        = driven ? second_half_reg : !second_half_reg;

            if (half_end)
            begin
                div_next = '0;
                if (second_half_reg)
                begin
                    second_half_next = 1'b0;
                    if (sample)
                    begin
                        sampled_next = {sampled_reg[14:0], in_word.mdio_in};
                    end
                    if (last)
                    begin
                        active_next       = 1'b0;
                        cell_next         = '0;
                        res_word.done_res = 1'b1;
                    end
                    else
                    begin
                        cell_next = cell_reg + 7'd1;
                    end
                end
                else
                begin
                    second_half_next = 1'b1;
                end
            end
            else
            begin
                div_next = div_reg + 8'd1;
            end
        end

        res_word.read_data = sampled_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            cell_reg        <= '0;
            second_half_reg <= 1'b0;
            div_reg         <= '0;
            shift_reg       <= '0;
            read_frame_reg  <= 1'b0;
            sampled_reg     <= '0;
        end
        else if (step)
        begin
            active_reg      <= active_next;
            cell_reg        <= cell_next;
            second_half_reg <= second_half_next;
            div_reg         <= div_next;
            shift_reg       <= shift_next;
            read_frame_reg  <= read_frame_next;
            sampled_reg     <= sampled_next;
        end
    end

    a_request_starts: assert property (@(posedge clk) disable iff (!rst_n)
        step && !active_reg && in_word.request |=> active_reg && (cell_reg == 7'd0))
        else $error("accepted request did not start a frame");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_word.done_res |=> !active_reg && (cell_reg == 7'd0))
        else $error("frame still active after done");

    a_sample_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        step && (sampled_next != sampled_reg) |-> active_reg && read_frame_reg && !driven)
        else $error("sampled bits changed outside a read data cell");

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> !res_word.busy_res && !res_word.mdio_drive && !res_word.mdc)
        else $error("idle engine shows frame activity");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the clause 22 MDIO management frame master.
// Predicts every result word from its own frame model and checks it; uses mfm_pkg and the DUT.
module tb_top;
    import mfm_pkg::*;

    typedef enum int {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_NONE} idle_mode_t;

    localparam int PIN_LOW      = 0;
    localparam int PIN_HIGH     = 1;
    localparam int PIN_RANDOM   = 2;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_WORDS = 400;
    localparam int PHASE_WORDS  = 80;
    localparam int HOLD_CYCLES  = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    in_word_t    tick_queue[$];
    res_word_t   expected_pins[$];
    res_word_t   want;
    res_word_t   got;
    idle_mode_t  idle_mode = IDLE_RX_HEAVY;
    logic        in_taken = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;
    int          cycle_count = 0;
    int          fail_count = 0;
    int          queued_words = 0;

    logic [7:0]  half_cycles_reg = HALF_PERIOD_RESET;
    logic [5:0]  preamble_reg = PREAMBLE_RESET;
    logic [1:0]  start_reg = START_RESET;

    logic        frame_busy = 1'b0;
    logic [6:0]  cell_index = '0;
    logic        in_second_half = 1'b0;
    logic [7:0]  half_count = '0;
    logic [31:0] frame_bits = '0;
    logic        is_read = 1'b0;
    logic [15:0] read_bits = '0;

    mdio_management_frame_master DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic res_word_t mdio_tick(input in_word_t w);
        res_word_t  r;
        logic [5:0] pre;
        logic [7:0] half;
        logic [6:0] k;
        logic       driven;
        logic       sample;
        logic       last;
        logic       bit_level;
        r = '0;
        if (!frame_busy)
        begin
            if (w.request)
            begin
                frame_bits = {start_reg, w.opcode, w.phy_address, w.register_address,
                              TA_PATTERN, w.write_data};
                is_read = w.opcode[1];
                frame_busy = 1'b1;
                cell_index = '0;
                in_second_half = 1'b0;
                half_count = '0;
            end
        end
        else
        begin
            pre = (preamble_reg > MAX_PREAMBLE) ? MAX_PREAMBLE : preamble_reg;
            half = (half_cycles_reg == 8'd0) ? 8'd1 : half_cycles_reg;
            sample = 1'b0;
            last = 1'b0;
            bit_level = 1'b0;
            driven = 1'b0;
            r.busy_res = 1'b1;
            if (cell_index < {1'b0, pre})
            begin
                driven = 1'b1;
                bit_level = 1'b1;
            end
            else
            begin
                k = cell_index - {1'b0, pre};
                if (k < HEADER_CELLS || (!is_read && k < WRITE_LAST_CELL))
                begin
                    driven = 1'b1;
                    bit_level = frame_bits[5'd31 - k[4:0]];
                end
                else if (is_read)
                begin
                    if (k > READ_TA_CELL && k < READ_LAST_CELL)
                        sample = 1'b1;
                    else if (k >= READ_LAST_CELL)
                        last = 1'b1;
                end
                else
                    last = 1'b1;
            end
            r.mdc = driven ? in_second_half : ~in_second_half;
            r.mdio_drive = driven;
            r.mdio_out = driven & bit_level;
            if ({1'b0, half_count} + 9'd1 >= {1'b0, half})
            begin
                half_count = '0;
                if (in_second_half)
                begin
                    in_second_half = 1'b0;
                    if (sample)
                        read_bits = {read_bits[14:0], w.mdio_in};
                    if (last)
                    begin
                        frame_busy = 1'b0;
                        cell_index = '0;
                        r.done_res = 1'b1;
                    end
                    else
                        cell_index = cell_index + 7'd1;
                end
                else
                    in_second_half = 1'b1;
            end
            else
                half_count = half_count + 8'd1;
        end
        r.read_data = read_bits;
        return r;
    endfunction

    function automatic int frame_len();
        int pre;
        int half;
        pre = int'((preamble_reg > MAX_PREAMBLE) ? MAX_PREAMBLE : preamble_reg);
        half = (half_cycles_reg == 8'd0) ? 1 : int'(half_cycles_reg);
        return (pre + 33) * 2 * half + 2;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    task automatic queue_request(input logic [1:0] op, input logic [4:0] phy,
                                 input logic [4:0] regad, input logic [15:0] data,
                                 input logic pin);
        in_word_t w;
        w = '0;
        w.request = 1'b1;
        w.opcode = op;
        w.phy_address = phy;
        w.register_address = regad;
        w.write_data = data;
        w.mdio_in = pin;
        tick_queue.push_back(w);
        queued_words++;
    endtask

    task automatic queue_ticks(input int n, input int req_pct, input int pin_mode);
        in_word_t w;
        repeat (n)
        begin
            w = '0;
            w.request = ($urandom_range(99) < req_pct);
            w.opcode = 2'($urandom);
            w.phy_address = 5'($urandom);
            w.register_address = 5'($urandom);
            w.write_data = 16'($urandom);
            w.mdio_in = (pin_mode == PIN_RANDOM) ? 1'($urandom) : (pin_mode == PIN_HIGH);
            tick_queue.push_back(w);
            queued_words++;
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (tick_queue.size() != 0 || expected_pins.size() != 0 || s_tvalid);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_HALF_PERIOD: half_cycles_reg = val;
            CFG_PREAMBLE:    preamble_reg = val[5:0];
            CFG_START:       start_reg = val[1:0];
            default:         ;
        endcase
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_taken)
        begin
            if (tick_queue.size() > 0 && $urandom_range(99) >=
                ((idle_mode == IDLE_RX_HEAVY) ? 38 : (idle_mode == IDLE_TX_HEAVY) ? 72 : 0))
            begin
                s_tvalid <= 1'b1;
                s_tdata <= tick_queue[0];
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            m_tready <= $urandom_range(99) >=
                ((idle_mode == IDLE_RX_HEAVY) ? 72 : (idle_mode == IDLE_TX_HEAVY) ? 38 : 0);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("mdio_management_frame_master test failed");
                $finish;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_pins.size() == 0)
                begin
                    $error("result word with no expected word waiting");
                    fail_count++;
                end
                else
                begin
                    want = expected_pins.pop_front();
                    got = res_word_t'(m_tdata);
                    check_field("mdc", 32'(want.mdc), 32'(got.mdc));
                    check_field("mdio_out", 32'(want.mdio_out), 32'(got.mdio_out));
                    check_field("mdio_drive", 32'(want.mdio_drive), 32'(got.mdio_drive));
                    check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
                    check_field("done_res", 32'(want.done_res), 32'(got.done_res));
                    check_field("read_data", 32'(want.read_data), 32'(got.read_data));
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_pins.push_back(mdio_tick(in_word_t'(s_tdata)));
                void'(tick_queue.pop_front());
            end
            in_taken <= s_tvalid && s_tready;
        end
    end

    initial
    begin
        int random_start;
        int phase_end;
        int phase_count;
        int pick;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A write frame at the reset settings, cut short by a live register change.
        queue_request(2'b01, 5'h1F, 5'h00, 16'hFFFF, 1'b0);
        queue_ticks(150, 0, PIN_RANDOM);
        wait_drained();
        cfg_write(CFG_HALF_PERIOD, 8'd1);
        cfg_write(CFG_PREAMBLE, 8'd0);
        cfg_write(CFG_START, 8'd0);
        cfg_valid <= 1'b0;
        @(posedge clk);
        queue_ticks(frame_len(), 0, PIN_RANDOM);
        queue_request(2'b00, 5'h00, 5'h1F, 16'h0000, 1'b1);
        queue_request(2'b11, 5'h1F, 5'h1F, 16'hFFFF, 1'b1);
        queue_ticks(frame_len(), 0, PIN_RANDOM);
        queue_request(2'b10, 5'h1F, 5'h00, 16'h0000, 1'b1);
        queue_ticks(frame_len(), 0, PIN_HIGH);
        queue_request(2'b11, 5'h00, 5'h1F, 16'hFFFF, 1'b0);
        queue_ticks(frame_len(), 0, PIN_LOW);
        wait_drained();

        // Zero half period and an over-long preamble.
        cfg_write(CFG_HALF_PERIOD, 8'd0);
        cfg_write(CFG_PREAMBLE, 8'd63);
        cfg_write(CFG_START, 8'd3);
        cfg_valid <= 1'b0;
        @(posedge clk);
        queue_request(2'b01, 5'h15, 5'h0A, 16'hA5C3, 1'b0);
        queue_ticks(frame_len(), 0, PIN_RANDOM);
        queue_request(2'b11, 5'h0A, 5'h15, 16'h5A3C, 1'b0);
        queue_ticks(frame_len(), 0, PIN_RANDOM);
        wait_drained();

        // The slowest MDC, then a faster one applied in the middle of the frame.
        cfg_write(CFG_HALF_PERIOD, 8'd255);
        cfg_write(CFG_PREAMBLE, 8'd32);
        cfg_write(CFG_START, 8'd2);
        cfg_valid <= 1'b0;
        @(posedge clk);
        queue_request(2'b10, 5'h11, 5'h02, 16'h1234, 1'b1);
        queue_ticks(300, 0, PIN_RANDOM);
        wait_drained();
        cfg_write(CFG_HALF_PERIOD, 8'd2);
        cfg_write(CFG_PREAMBLE, 8'd5);
        cfg_valid <= 1'b0;
        @(posedge clk);
        queue_ticks(frame_len(), 0, PIN_RANDOM);

        phase_count = 0;
        random_start = queued_words;
        while ((queued_words - random_start < RANDOM_WORDS) || (phase_count < 3))
        begin
            wait_drained();
            if ($urandom_range(1))
            begin
                pick = $urandom_range(99);
                cfg_write(CFG_HALF_PERIOD, 8'((pick < 60) ? $urandom_range(1, 2) :
                                              (pick < 85) ? $urandom_range(3, 6) :
                                              (pick < 95) ? 0 : $urandom_range(7, 16)));
            end
            if ($urandom_range(1))
            begin
                pick = $urandom_range(99);
                cfg_write(CFG_PREAMBLE, 8'((pick < 50) ? $urandom_range(0, 3) :
                                           (pick < 80) ? $urandom_range(4, 31) :
                                           (pick < 90) ? 32 : $urandom_range(33, 63)));
            end
            if ($urandom_range(1))
                cfg_write(CFG_START, 8'($urandom_range(3)));
            cfg_valid <= 1'b0;
            @(posedge clk);
            idle_mode = (phase_count == 0) ? IDLE_RX_HEAVY :
                        (phase_count == 1) ? IDLE_TX_HEAVY : IDLE_NONE;
            phase_end = queued_words + PHASE_WORDS;
            while (queued_words < phase_end)
            begin
                if ($urandom_range(99) < 85)
                begin
                    queue_request(2'($urandom), 5'($urandom), 5'($urandom), 16'($urandom),
                                  1'($urandom));
                    queue_ticks(frame_len() + $urandom_range(3), 2, PIN_RANDOM);
                end
                else
                    queue_ticks($urandom_range(1, frame_len()), 20, PIN_RANDOM);
            end
            if (idle_mode == IDLE_NONE)
                hold_req = 1'b1;
            phase_count++;
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("mdio_management_frame_master test passed");
        else
            $display("mdio_management_frame_master test failed");
        $finish;
    end

endmodule
